// ===== sv/ofht_pkg.sv =====
package ofht_pkg;

	localparam int HANDLE_W = 10;
	localparam int INODE_W  = 16;
	localparam int OFFSET_W = 32;
	localparam int ENTRY_W  = INODE_W + OFFSET_W;

	typedef enum logic [1:0] {
		OP_OPEN  = 2'd0,
		OP_CLOSE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		op_t                 operation;
		logic [INODE_W-1:0]  inode_number;
		logic [OFFSET_W-1:0] start_offset;
		logic [HANDLE_W-1:0] handle_in;
	} req_word_t;

	typedef struct packed {
		logic                status;
		logic [HANDLE_W-1:0] handle_out;
		logic [INODE_W-1:0]  entry_inode;
		logic [OFFSET_W-1:0] entry_offset;
		logic                entry_taken;
	} rsp_word_t;

endpackage

// ===== sv/ofht_chan_if.sv =====
interface ofht_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ===== sv/open_file_handle_table.sv =====
// Handle table of SLOTS entries. Open takes the lowest free slot, close frees a
// taken slot, read returns a slot's inode, offset and taken flag. Open and close
// answer in the cycle after they are accepted; a read is answered after the
// registered read of the entry memory. One request is in work at a time, so no
// new request is taken while a read waits for its entry or while a result word
// waits on the result side. After reset a clearing pass zeroes the entry memory,
// one entry a cycle; no request is accepted until it ends.
module open_file_handle_table
	import ofht_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ofht_chan_if.sink   req,
	ofht_chan_if.source rsp
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    clr_idx_q;
	logic [SLOTS-1:0]    taken_q;
	logic                out_valid_q;
	rsp_word_t           out_q;
	logic [HANDLE_W-1:0] rd_handle_q;
	logic                rd_taken_q;
	logic [ENTRY_W-1:0]  rd_data_q;
	logic [ENTRY_W-1:0]  entry_mem [SLOTS];

	logic                out_free;
	logic                req_fire;
	logic                in_range;
	logic [IDX_W-1:0]    req_idx;
	logic                slot_taken;
	logic                full;
	logic [IDX_W-1:0]    free_idx;
	logic                read_go;
	logic                load_out;
	rsp_word_t           out_next;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [ENTRY_W-1:0]  mem_wdata;

	// handshake
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.word  = out_q;

	// request decode
	assign in_range   = {1'b0, req.word.handle_in} < (HANDLE_W + 1)'(SLOTS);
	assign req_idx    = req.word.handle_in[IDX_W-1:0];
	assign slot_taken = in_range && taken_q[req_idx];
	assign read_go    = req_fire && (req.word.operation == OP_READ) && in_range;

	// lowest free slot
	always_comb begin
		full     = 1'b1;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!taken_q[i]) begin
				full     = 1'b0;
				free_idx = IDX_W'(i);
			end
		end
	end

	// result word
	always_comb begin
		out_next        = '0;
		out_next.status = STATUS_FAIL;
		if (state_q == ST_READ) begin
			out_next.status       = STATUS_OK;
			out_next.handle_out   = rd_handle_q;
			out_next.entry_inode  = rd_data_q[ENTRY_W-1 -: INODE_W];
			out_next.entry_offset = rd_data_q[OFFSET_W-1:0];
			out_next.entry_taken  = rd_taken_q;
		end else begin
			case (req.word.operation)
				OP_OPEN: begin
					if (!full) begin
						out_next.status     = STATUS_OK;
						out_next.handle_out = HANDLE_W'(free_idx);
					end
				end
				OP_CLOSE: begin
					out_next.handle_out = req.word.handle_in;
					if (slot_taken) begin
						out_next.status = STATUS_OK;
					end
				end
				OP_READ: begin
					out_next.handle_out = req.word.handle_in;
				end
				default: begin
					out_next.handle_out = '0;
				end
			endcase
		end
	end

	assign load_out = (req_fire && !read_go) || ((state_q == ST_READ) && out_free);

	// memory write port: clearing pass or open
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = free_idx;
		mem_wdata = {req.word.inode_number, req.word.start_offset};
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else if (req_fire && (req.word.operation == OP_OPEN) && !full) begin
			mem_we = 1'b1;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_waddr] <= mem_wdata;
		end
		if (read_go) begin
			rd_data_q <= entry_mem[req_idx];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			taken_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (read_go) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// taken flags
			if (req_fire && (req.word.operation == OP_OPEN) && !full) begin
				taken_q[free_idx] <= 1'b1;
			end else if (req_fire && (req.word.operation == OP_CLOSE) && slot_taken) begin
				taken_q[req_idx] <= 1'b0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_next;
		end
		if (read_go) begin
			rd_handle_q <= req.word.handle_in;
			rd_taken_q  <= slot_taken;
		end
	end

	// no request taken while the memory is being cleared
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request accepted during clearing pass");

	// a pending word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !load_out)
		else $error("result word overwritten before it was taken");

	// an in-range read goes to the memory wait state
	a_read_wait: assert property (@(posedge clk) disable iff (!arst_n)
		read_go |=> (state_q == ST_READ))
		else $error("read did not wait for memory data");

	// a granted slot is marked taken
	a_open_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.word.operation == OP_OPEN) && !full)
		|=> taken_q[$past(free_idx)])
		else $error("granted slot not marked taken");

	// a successful open reports the slot it took
	a_open_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.word.operation == OP_OPEN) && !full)
		|=> (out_valid_q && (out_q.status == STATUS_OK)
			&& (out_q.handle_out == HANDLE_W'($past(free_idx)))))
		else $error("open result does not match granted slot");

endmodule

// ===== tb/ofht_checker.sv =====
// watches both channels of the handle table, keeps a shadow copy of the
// table and compares every response word with the predicted one
module ofht_checker
	import ofht_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_word_t req_word,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_word_t rsp_word,
	output int        fails,
	output int        pending
);

	logic                shadow_taken [SLOTS];
	logic [INODE_W-1:0]  shadow_inode [SLOTS];
	logic [OFFSET_W-1:0] shadow_offset[SLOTS];
	rsp_word_t           answers_due[$];
	rsp_word_t           oldest;

	// one line per mismatch
	task automatic report(input string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		fails++;
	endtask

	// works out the response to one request and updates the shadow table
	function automatic rsp_word_t handle_table_answer(input req_word_t r);
		rsp_word_t   a;
		int unsigned h;
		bit          found;
		a = '0;
		h = r.handle_in;
		found = 1'b0;
		case (r.operation)
			OP_OPEN: begin
				// lowest free slot wins
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && !shadow_taken[i]) begin
						found = 1'b1;
						shadow_taken[i] = 1'b1;
						shadow_inode[i] = r.inode_number;
						shadow_offset[i] = r.start_offset;
						a.handle_out = HANDLE_W'(i);
					end
				end
				a.status = found ? STATUS_OK : STATUS_FAIL;
			end
			OP_CLOSE: begin
				a.handle_out = r.handle_in;
				if (h < SLOTS && shadow_taken[h]) begin
					shadow_taken[h] = 1'b0;
					a.status = STATUS_OK;
				end else begin
					a.status = STATUS_FAIL;
				end
			end
			OP_READ: begin
				a.handle_out = r.handle_in;
				if (h < SLOTS) begin
					// free slots still report what they last held
					a.status = STATUS_OK;
					a.entry_inode = shadow_inode[h];
					a.entry_offset = shadow_offset[h];
					a.entry_taken = shadow_taken[h];
				end else begin
					a.status = STATUS_FAIL;
				end
			end
			default: begin
				a.status = STATUS_FAIL;
			end
		endcase
		return a;
	endfunction

	// response side first: a word accepted now was requested earlier
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				shadow_taken[i] = 1'b0;
				shadow_inode[i] = '0;
				shadow_offset[i] = '0;
			end
			answers_due.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					report($sformatf("response word with nothing outstanding: %0h", rsp_word));
				end else begin
					oldest = answers_due.pop_front();
					if (rsp_word.status !== oldest.status)
						report($sformatf("status got %0h want %0h",
							rsp_word.status, oldest.status));
					if (rsp_word.handle_out !== oldest.handle_out)
						report($sformatf("handle_out got %0h want %0h",
							rsp_word.handle_out, oldest.handle_out));
					if (rsp_word.entry_inode !== oldest.entry_inode)
						report($sformatf("entry_inode got %0h want %0h",
							rsp_word.entry_inode, oldest.entry_inode));
					if (rsp_word.entry_offset !== oldest.entry_offset)
						report($sformatf("entry_offset got %0h want %0h",
							rsp_word.entry_offset, oldest.entry_offset));
					if (rsp_word.entry_taken !== oldest.entry_taken)
						report($sformatf("entry_taken got %0h want %0h",
							rsp_word.entry_taken, oldest.entry_taken));
				end
			end
			if (req_valid && req_ready)
				answers_due.push_back(handle_table_answer(req_word));
			pending = answers_due.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	import ofht_pkg::*;

	localparam int SLOTS       = 64;
	localparam int RANDOM_REQS = 1880;
	localparam int PHASES      = 5;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 300000;

	typedef enum {MIX_OPS, FILL_OPS, DRAIN_OPS} op_mix_t;

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycles;
	bit   steady;
	bit   hold_rsp;

	ofht_chan_if #(.word_t(req_word_t)) req_if ();
	ofht_chan_if #(.word_t(rsp_word_t)) rsp_if ();

	open_file_handle_table #(.SLOTS(SLOTS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	ofht_checker #(.SLOTS(SLOTS)) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_if.valid),
		.req_ready (req_if.ready),
		.req_word  (req_if.word),
		.rsp_valid (rsp_if.valid),
		.rsp_ready (rsp_if.ready),
		.rsp_word  (rsp_if.word),
		.fails     (fails),
		.pending   (pending)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// response side: random stalls, or one long hold when asked
	initial begin
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_if.ready <= 1'b0;
				hold_rsp = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_if.ready <= steady || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	function automatic req_word_t make_req(input op_t op, input logic [INODE_W-1:0] ino,
		input logic [OFFSET_W-1:0] off, input logic [HANDLE_W-1:0] h);
		req_word_t r;
		r.operation = op;
		r.inode_number = ino;
		r.start_offset = off;
		r.handle_in = h;
		return r;
	endfunction

	// random request, op mix biased to fill or drain the table
	function automatic req_word_t random_request(input op_mix_t mix);
		req_word_t   r;
		int unsigned pick;
		int unsigned open_pct;
		int unsigned close_pct;
		int unsigned read_pct;
		case (mix)
			FILL_OPS: begin
				open_pct = 70; close_pct = 10; read_pct = 15;
			end
			DRAIN_OPS: begin
				open_pct = 10; close_pct = 70; read_pct = 15;
			end
			default: begin
				open_pct = 35; close_pct = 35; read_pct = 25;
			end
		endcase
		pick = $urandom_range(0, 99);
		if (pick < open_pct)
			r.operation = OP_OPEN;
		else if (pick < open_pct + close_pct)
			r.operation = OP_CLOSE;
		else if (pick < open_pct + close_pct + read_pct)
			r.operation = OP_READ;
		else
			r.operation = OP_NONE;
		r.inode_number = INODE_W'($urandom_range(0, 65535));
		r.start_offset = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 8)
			r.handle_in = HANDLE_W'($urandom_range(0, SLOTS - 1));
		else if (pick == 8)
			r.handle_in = HANDLE_W'($urandom_range(SLOTS, 1023));
		else
			r.handle_in = HANDLE_W'($urandom_range(0, 1023));
		return r;
	endfunction

	// present one request word and hold it until accepted
	task automatic offer(input req_word_t w);
		req_if.valid <= 1'b1;
		req_if.word <= w;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	// random one-cycle gap on the request side
	task automatic maybe_gap;
		if (!steady && $urandom_range(0, 99) < 16) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop offering until every outstanding response has come back
	task automatic drain_wait;
		req_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	req_word_t directed[$];
	op_mix_t   mix;

	// stimulus and verdict
	initial begin
		steady = 1'b0;
		hold_rsp = 1'b0;
		arst_n = 1'b0;
		req_if.valid <= 1'b0;
		req_if.word <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, bad handles, extremes, reuse of a freed slot
		directed.push_back(make_req(OP_READ, '0, '0, 10'd0));
		directed.push_back(make_req(OP_READ, '0, '0, 10'(SLOTS - 1)));
		directed.push_back(make_req(OP_READ, '0, '0, 10'(SLOTS)));
		directed.push_back(make_req(OP_READ, '1, '1, 10'h3ff));
		directed.push_back(make_req(OP_CLOSE, '0, '0, 10'd0));
		directed.push_back(make_req(OP_CLOSE, '0, '0, 10'h3ff));
		directed.push_back(make_req(OP_NONE, '1, '1, 10'h3ff));
		directed.push_back(make_req(OP_OPEN, 16'hffff, 32'hffff_ffff, 10'h3ff));
		directed.push_back(make_req(OP_OPEN, '0, '0, '0));
		directed.push_back(make_req(OP_OPEN, 16'h5a5a, 32'h8000_0001, 10'h155));
		directed.push_back(make_req(OP_READ, '0, '0, 10'd0));
		directed.push_back(make_req(OP_READ, '0, '0, 10'd1));
		directed.push_back(make_req(OP_READ, '0, '0, 10'd2));
		directed.push_back(make_req(OP_CLOSE, '0, '0, 10'd1));
		directed.push_back(make_req(OP_CLOSE, '0, '0, 10'd1));
		directed.push_back(make_req(OP_READ, '0, '0, 10'd1));
		directed.push_back(make_req(OP_OPEN, 16'ha5a5, 32'h7fff_fffe, '0));
		directed.push_back(make_req(OP_READ, '0, '0, 10'd1));
		directed.push_back(make_req(OP_CLOSE, '0, '0, 10'(SLOTS)));
		directed.push_back(make_req(OP_NONE, '0, '0, '0));
		directed.push_back(make_req(OP_READ, '0, '0, 10'h2aa));
		directed.push_back(make_req(OP_CLOSE, '0, '0, 10'd2));
		foreach (directed[i]) begin
			maybe_gap();
			offer(directed[i]);
		end

		// random phases: mixed, fill without idling, drain behind a long
		// response hold, fill after a full drain, mixed
		for (int p = 0; p < PHASES; p++) begin
			steady = (p == 1);
			case (p)
				1, 3: mix = FILL_OPS;
				2: mix = DRAIN_OPS;
				default: mix = MIX_OPS;
			endcase
			if (p == 2)
				hold_rsp = 1'b1;
			if (p == 3)
				drain_wait();
			for (int n = 0; n < RANDOM_REQS / PHASES; n++) begin
				maybe_gap();
				offer(random_request(mix));
			end
		end
		steady = 1'b0;

		drain_wait();
		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
